### src/gcsm_pkg.sv
// ----------------------------------------------------------------------------
// gcsm_pkg: shared definitions for the circular stick mapper
// Constants, interface types and the hat decode table used by the mapper
// top level and its shared arithmetic unit.
// ----------------------------------------------------------------------------
package gcsm_pkg;

  // Reports shorter than this many bytes are dropped.
  localparam logic [6:0]  MinReportBytes = 7'd6;

  // Stick centre and the square-to-circle normalization constants.
  localparam logic [7:0]  AxisCentre     = 8'd128;
  localparam logic [15:0] RadicandOffset = 16'h8000;  // 2 * 128 * 128
  localparam logic [8:0]  CircleNorm     = 9'd181;
  localparam logic [7:0]  AxisMax        = 8'hFF;

  // Division by 181 is a multiply by ceil(2**22 / 181) and a shift by 22.
  // For products up to 128 * 181 the quotient comes out exact.
  localparam logic [14:0] CircleRecip      = 15'd23173;
  localparam int unsigned CircleRecipShift = 22;

  // The square root retires one result bit per step.
  localparam int unsigned NumSteps = 8;
  localparam int unsigned StepW    = $clog2(NumSteps);

  // Hat switch codes.
  localparam logic [3:0] HatN        = 4'd0;
  localparam logic [3:0] HatNE       = 4'd1;
  localparam logic [3:0] HatE        = 4'd2;
  localparam logic [3:0] HatSE       = 4'd3;
  localparam logic [3:0] HatS        = 4'd4;
  localparam logic [3:0] HatSW       = 4'd5;
  localparam logic [3:0] HatW        = 4'd6;
  localparam logic [3:0] HatNW       = 4'd7;

  // D-pad bit positions in the button word.
  localparam int unsigned DpadUp    = 0;
  localparam int unsigned DpadRight = 1;
  localparam int unsigned DpadDown  = 2;
  localparam int unsigned DpadLeft  = 3;

  // Bits of report byte five that feed the trigger levels.
  localparam int unsigned BtnL2 = 2;
  localparam int unsigned BtnR2 = 3;

  // Command from the sequencer to the shared axis unit.
  typedef struct packed {
    logic       start;
    logic [7:0] self_raw;
    logic [7:0] other_raw;
  } gcsm_axis_cmd_t;

  // Status from the shared axis unit back to the sequencer.
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] value;
  } gcsm_axis_sts_t;

  // Hat code to d-pad bits {left, down, right, up}; released and
  // unused codes give no direction.
  function automatic logic [3:0] hat_to_dpad(input logic [3:0] hat);
    logic [3:0] dpad;
    dpad = '0;
    case (hat)
      HatN:    dpad[DpadUp] = 1'b1;
      HatNE:   begin
        dpad[DpadUp]    = 1'b1;
        dpad[DpadRight] = 1'b1;
      end
      HatE:    dpad[DpadRight] = 1'b1;
      HatSE:   begin
        dpad[DpadRight] = 1'b1;
        dpad[DpadDown]  = 1'b1;
      end
      HatS:    dpad[DpadDown] = 1'b1;
      HatSW:   begin
        dpad[DpadDown] = 1'b1;
        dpad[DpadLeft] = 1'b1;
      end
      HatW:    dpad[DpadLeft] = 1'b1;
      HatNW:   begin
        dpad[DpadLeft] = 1'b1;
        dpad[DpadUp]   = 1'b1;
      end
      default: dpad = '0;
    endcase
    return dpad;
  endfunction

endpackage

### src/gcsm_axis_unit.sv
// ----------------------------------------------------------------------------
// gcsm_axis_unit: shared square-to-circle axis arithmetic
// Maps one raw axis given the other axis of the same stick, using one shared
// multiplier, a bit-serial square root and a reciprocal multiply for the
// divide by 181.
// ----------------------------------------------------------------------------
module gcsm_axis_unit
  import gcsm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gcsm_axis_cmd_t cmd_i,
  output gcsm_axis_sts_t sts_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_MUL,
    ST_RECIP,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             done_q;
  logic [7:0]       value_q;

  logic [7:0]  self_mag_q, other_mag_q;
  logic        self_neg_q;
  logic [15:0] rad_q;
  logic [7:0]  root_q;
  logic [8:0]  rem_q;
  logic [14:0] prod_q;
  logic [7:0]  quot_q;

  // Magnitude of the centred value raw - 128.
  logic [7:0] self_mag_d, other_mag_d;
  assign self_mag_d  = cmd_i.self_raw[7]  ? {1'b0, cmd_i.self_raw[6:0]}
                                          : AxisCentre - cmd_i.self_raw;
  assign other_mag_d = cmd_i.other_raw[7] ? {1'b0, cmd_i.other_raw[6:0]}
                                          : AxisCentre - cmd_i.other_raw;

  // The one multiplier: squares the other axis, scales this axis by the
  // root, then multiplies that product by the reciprocal of 181.
  logic [14:0] mul_a, mul_b;
  logic [29:0] mul_p;
  always_comb begin
    case (state_q)
      ST_SQUARE: begin
        mul_a = {7'b0, other_mag_q};
        mul_b = {7'b0, other_mag_q};
      end
      ST_MUL: begin
        mul_a = {7'b0, self_mag_q};
        mul_b = {7'b0, root_q};
      end
      default: begin
        mul_a = prod_q;
        mul_b = CircleRecip;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Square root step: bring down two radicand bits, try (root << 2) | 1.
  logic [10:0] rem_sh, trial, rem_sub;
  logic        root_ge;
  assign rem_sh  = {rem_q, rad_q[15:14]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ge = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  // Re-offset around the centre and clamp to the byte range.
  logic signed [9:0] sum;
  logic [7:0]        clamped;
  always_comb begin
    if (self_neg_q) begin
      sum = $signed({2'b00, AxisCentre}) - $signed({2'b00, quot_q});
    end else begin
      sum = $signed({2'b00, AxisCentre}) + $signed({2'b00, quot_q});
    end
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed({2'b00, AxisMax})) begin
      clamped = AxisMax;
    end else begin
      clamped = sum[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_i.start) begin
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          step_q  <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(NumSteps - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_RECIP;
        end
        ST_RECIP: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          self_mag_q  <= self_mag_d;
          other_mag_q <= other_mag_d;
          self_neg_q  <= ~cmd_i.self_raw[7];
        end
      end
      ST_SQUARE: begin
        rad_q  <= RadicandOffset - mul_p[15:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rad_q  <= {rad_q[13:0], 2'b00};
        rem_q  <= root_ge ? rem_sub[8:0] : rem_sh[8:0];
        root_q <= {root_q[6:0], root_ge};
      end
      ST_MUL: begin
        // The product is at most 128 * 181, so fifteen bits hold it.
        prod_q <= mul_p[14:0];
      end
      ST_RECIP: begin
        // The quotient is at most 128 and fits in one byte.
        quot_q <= mul_p[CircleRecipShift +: 8];
      end
      ST_FIN: begin
        value_q <= clamped;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.busy  = (state_q != ST_IDLE);
  assign sts_o.done  = done_q;
  assign sts_o.value = value_q;

endmodule

### src/gamepad_report_circular_stick_mapper_unit.sv
// ----------------------------------------------------------------------------
// gamepad_report_circular_stick_mapper_unit: gamepad report stick mapper
// Maps the square-gate sticks of a six-byte report onto a circle and
// repacks the hat and buttons into one button word.
// ----------------------------------------------------------------------------
// Usage:
// Reports enter on the s_axis channel, one item per report, and mapped
// reports leave on the m_axis channel. A report whose length field is below
// six bytes is taken and dropped: it gives no output item and the input is
// ready again in the next cycle.
// A full report is worked on by one shared axis unit, one axis after the
// other. Each axis goes through the start hand-off, one multiply for the
// square of the other axis, eight square-root steps, one multiply by the
// root, one multiply by the reciprocal of 181, the clamp and the done
// hand-off. The input is not ready for the next report until the mapped
// item has been loaded into the output register.
// The mapped item sits in an output register. While it waits for the
// receiver, the input side stays ready and the next report is worked on; the
// sequencer holds in its final state only if that next result is done before
// the previous one was taken.
// Reset clears the sequencer and the output valid flag; nothing else is
// kept from one report to the next.
// ----------------------------------------------------------------------------
module gamepad_report_circular_stick_mapper_unit
  import gcsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: left_x_raw, left_y_raw, right_x_raw, right_y_raw,
  // hat_and_face, shoulder_and_system, report_length (7), one zero pad bit.
  input  logic [55:0] s_axis_tdata_i,

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: left_x, left_y, right_x, right_y, buttons (16),
  // left_trigger_level, right_trigger_level.
  output logic [63:0] m_axis_tdata_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_PUSH
  } state_e;

  state_e     state_q;
  logic [1:0] axis_idx_q;
  logic       out_valid_q;
  logic [63:0] out_data_q;

  // Captured report and per-axis results.
  logic [7:0] stick_q [4];
  logic [7:0] hat_face_q;
  logic [7:0] shoulder_q;
  logic [7:0] res_q [4];

  gcsm_axis_cmd_t axis_cmd;
  gcsm_axis_sts_t axis_sts;

  logic in_accept;
  logic long_enough;
  logic out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign long_enough     = (s_axis_tdata_i[54:48] >= MinReportBytes);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Each axis is mapped against the other axis of its own stick.
  always_comb begin
    axis_cmd.start = (state_q == S_START);
    case (axis_idx_q)
      2'd0: begin
        axis_cmd.self_raw  = stick_q[0];
        axis_cmd.other_raw = stick_q[1];
      end
      2'd1: begin
        axis_cmd.self_raw  = stick_q[1];
        axis_cmd.other_raw = stick_q[0];
      end
      2'd2: begin
        axis_cmd.self_raw  = stick_q[2];
        axis_cmd.other_raw = stick_q[3];
      end
      default: begin
        axis_cmd.self_raw  = stick_q[3];
        axis_cmd.other_raw = stick_q[2];
      end
    endcase
  end

  gcsm_axis_unit u_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (axis_cmd),
    .sts_o  (axis_sts)
  );

  // Button word: d-pad, face buttons, then byte five unchanged on top.
  logic [15:0] buttons;
  logic [7:0]  left_trig, right_trig;
  assign buttons    = {shoulder_q, hat_face_q[7:4], hat_to_dpad(hat_face_q[3:0])};
  assign left_trig  = shoulder_q[BtnL2] ? AxisMax : '0;
  assign right_trig = shoulder_q[BtnR2] ? AxisMax : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result replaces a taken one in the same cycle.
      if (state_q == S_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept && long_enough) begin
            axis_idx_q <= '0;
            state_q    <= S_START;
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          // The unit is still in its first state during the start cycle.
          if (axis_sts.done) begin
            if (axis_idx_q == 2'd3) begin
              state_q <= S_PUSH;
            end else begin
              axis_idx_q <= axis_idx_q + 1'b1;
              state_q    <= S_START;
            end
          end
        end
        S_PUSH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stick_q[0] <= s_axis_tdata_i[7:0];
      stick_q[1] <= s_axis_tdata_i[15:8];
      stick_q[2] <= s_axis_tdata_i[23:16];
      stick_q[3] <= s_axis_tdata_i[31:24];
      hat_face_q <= s_axis_tdata_i[39:32];
      shoulder_q <= s_axis_tdata_i[47:40];
    end
    if (state_q == S_WAIT && axis_sts.done) begin
      res_q[axis_idx_q] <= axis_sts.value;
    end
    if (state_q == S_PUSH && out_free) begin
      out_data_q <= {right_trig, left_trig, buttons,
                     res_q[3], res_q[2], res_q[1], res_q[0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### src/gcsm_checker.sv
// ----------------------------------------------------------------------------
// gcsm_checker: port-level checks for the circular stick mapper
// Watches the top level's channels and flags behavior the mapper must
// never show.
// ----------------------------------------------------------------------------
module gcsm_checker
  import gcsm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [55:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // No result is shown while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A waiting result stays until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  // A full report keeps the input closed while it is mapped.
  a_busy_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tdata_i[54:48] >= MinReportBytes) |=> !s_axis_tready_o)
    else $error("input ready while a report is being mapped");

  // A short report is dropped and the input is ready at once.
  a_short_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tdata_i[54:48] < MinReportBytes) |=> s_axis_tready_o)
    else $error("short report was not dropped");

  // Trigger levels follow the L2 and R2 bits of the button word.
  a_trig_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[55:48] == (m_axis_tdata_o[42] ? AxisMax : 8'h00)) &&
      (m_axis_tdata_o[63:56] == (m_axis_tdata_o[43] ? AxisMax : 8'h00)))
    else $error("trigger level does not match button bit");

endmodule

bind gamepad_report_circular_stick_mapper_unit gcsm_checker u_gcsm_checker (.*);

### bench/gamepad_report_circular_stick_mapper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_report_circular_stick_mapper_unit_tb: self-checking bench
// Drives six-byte gamepad reports into the stick mapper and checks every
// mapped report against an in-bench prediction of the stick circle mapping,
// the hat and button repacking and the trigger levels. Short reports must
// produce no output. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module gamepad_report_circular_stick_mapper_unit_tb;
  import gcsm_pkg::*;

  // Input item as carried on s_axis_tdata, last field in the top bits.
  typedef struct packed {
    logic       pad;
    logic [6:0] length;
    logic [7:0] shoulder_sys;
    logic [7:0] hat_face;
    logic [7:0] ry;
    logic [7:0] rx;
    logic [7:0] ly;
    logic [7:0] lx;
  } gamepad_report_t;

  // Output item as carried on m_axis_tdata.
  typedef struct packed {
    logic [7:0]  rt;
    logic [7:0]  lt;
    logic [15:0] buttons;
    logic [7:0]  ry;
    logic [7:0]  rx;
    logic [7:0]  ly;
    logic [7:0]  lx;
  } mapped_report_t;

  // Holds the mapped reports still owed by the block, oldest first.
  class report_scoreboard;
    mapped_report_t owed_q[$];
    int unsigned    full_reports;
    int unsigned    short_reports;
    int unsigned    checked;
    int unsigned    errors;

    function new();
      full_reports  = 0;
      short_reports = 0;
      checked       = 0;
      errors        = 0;
    endfunction

    // Integer square root, one result bit at a time from the top.
    function automatic int unsigned isqrt(input int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 8; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // One axis on the circle, given the other axis of the same stick.
    function automatic logic [7:0] circle_axis(input logic [7:0] self_raw,
                                               input logic [7:0] other_raw);
      int n;
      int m;
      int s;
      int r;
      n = int'(self_raw) - int'(AxisCentre);
      m = int'(other_raw) - int'(AxisCentre);
      s = int'(isqrt(int'(RadicandOffset) - m * m));
      r = int'(AxisCentre) + (n * s) / int'(CircleNorm);
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return r[7:0];
    endfunction

    // Accepted input item: work out the output item it owes, if any.
    function void note_report(input gamepad_report_t r);
      mapped_report_t want;
      logic [3:0]     dpad;
      if (r.length < MinReportBytes) begin
        short_reports++;
        return;
      end
      full_reports++;
      case (r.hat_face[3:0])
        HatN:    dpad = 4'b0001;
        HatNE:   dpad = 4'b0011;
        HatE:    dpad = 4'b0010;
        HatSE:   dpad = 4'b0110;
        HatS:    dpad = 4'b0100;
        HatSW:   dpad = 4'b1100;
        HatW:    dpad = 4'b1000;
        HatNW:   dpad = 4'b1001;
        default: dpad = 4'b0000;  // released and unused codes
      endcase
      want.lx      = circle_axis(r.lx, r.ly);
      want.ly      = circle_axis(r.ly, r.lx);
      want.rx      = circle_axis(r.rx, r.ry);
      want.ry      = circle_axis(r.ry, r.rx);
      want.buttons = {r.shoulder_sys, r.hat_face[7:4], dpad};
      want.lt      = r.shoulder_sys[BtnL2] ? 8'hFF : 8'h00;
      want.rt      = r.shoulder_sys[BtnR2] ? 8'hFF : 8'h00;
      owed_q.push_back(want);
    endfunction

    function bit field_ok(input string name, input logic [15:0] want,
                          input logic [15:0] got);
      if (want === got) return 1'b1;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      return 1'b0;
    endfunction

    // Output item taken by the receiver: compare with the oldest one owed.
    function void check_result(input mapped_report_t got);
      mapped_report_t want;
      bit             ok;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected output item 0x%0h, expected none", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      ok = field_ok("left_x", 16'(want.lx), 16'(got.lx));
      ok = field_ok("left_y", 16'(want.ly), 16'(got.ly)) && ok;
      ok = field_ok("right_x", 16'(want.rx), 16'(got.rx)) && ok;
      ok = field_ok("right_y", 16'(want.ry), 16'(got.ry)) && ok;
      ok = field_ok("buttons", want.buttons, got.buttons) && ok;
      ok = field_ok("left_trigger_level", 16'(want.lt), 16'(got.lt)) && ok;
      ok = field_ok("right_trigger_level", 16'(want.rt), 16'(got.rt)) && ok;
      if (!ok) errors++;
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic [55:0] s_data;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready;
  logic [63:0] m_data;

  report_scoreboard sb = new();

  // Idling switches; the first two are shared by the sender and the receiver.
  bit          idle_on      = 1'b1;
  bit          quiet_tail   = 1'b0;
  int unsigned hold_request = 0;

  gamepad_report_circular_stick_mapper_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic gamepad_report_t make_report(
      input logic [7:0] lx, input logic [7:0] ly, input logic [7:0] rx,
      input logic [7:0] ry, input logic [7:0] hat_face,
      input logic [7:0] shoulder_sys, input logic [6:0] length);
    gamepad_report_t r;
    r = '{pad: 1'b0, length: length, shoulder_sys: shoulder_sys,
          hat_face: hat_face, ry: ry, rx: rx, ly: ly, lx: lx};
    return r;
  endfunction

  // Stick byte, leaning toward the centre and the gate edges now and then.
  function automatic logic [7:0] pick_axis();
    logic [7:0] edges [7];
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic gamepad_report_t random_report();
    gamepad_report_t r;
    logic [3:0]      hat;
    // Most hat codes are real directions or released; some are unused.
    hat = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                      : 4'($urandom_range(0, 8));
    r = make_report(pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                    {4'($urandom_range(0, 15)), hat}, 8'($urandom_range(0, 255)),
                    7'($urandom_range(6, 64)));
    // A few reports come in short and must vanish without an output item.
    if ($urandom_range(0, 11) == 0) r.length = 7'($urandom_range(0, 5));
    return r;
  endfunction

  // Offer one item, with an optional idle burst in front, and wait for it
  // to be taken. Ready is sampled at the rising edge before the block
  // updates it, so valid and ready are seen as the block sees them.
  task automatic send_report(input gamepad_report_t r);
    int unsigned gap;
    gap = 0;
    if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= r;
    do @(posedge clk_i); while (!s_ready);
    sb.note_report(r);
  endtask

  // Stop offering and wait until every owed output item has come back.
  task automatic drain_outputs();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Receiver: ready drops in short random bursts, and for one long hold-off
  // when asked, which lets the block fill up and back-pressure its input.
  initial begin : receiver
    int unsigned stall;
    int unsigned held;
    stall   = 0;
    held    = 0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        held         = hold_request;
        hold_request = 0;
      end
      if (held != 0) begin
        held--;
        m_ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        m_ready <= 1'b0;
      end else if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
        stall   = $urandom_range(0, 3);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data);
  end

  // Main stimulus: directed reports, then a long random stream.
  initial begin : stimulus
    int unsigned items_sent;
    bit          mid_drain_done;
    gamepad_report_t r;
    s_valid = 1'b0;
    s_data  = '0;
    rst_ni  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Stick extremes, centre, opposing corners, and the length boundary.
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd6));
    send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd64));
    send_report(make_report(8'd128, 8'd128, 8'd128, 8'd128, 8'h08, 8'h00, 7'd6));
    send_report(make_report(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'h0C, 7'd7));
    send_report(make_report(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hA5, 8'hF3, 7'd63));
    send_report(make_report(8'hFF, 8'd128, 8'd128, 8'h00, 8'h18, 8'h04, 7'd5));
    send_report(make_report(8'h00, 8'd128, 8'hFF, 8'd128, 8'h28, 8'h08, 7'd0));
    // Every hat code, with the face and shoulder bits walked along.
    for (int h = 0; h < 16; h++) begin
      send_report(make_report(8'(h * 17), 8'(255 - h * 17), 8'(h * 16 + 1), 8'(h * 8),
                              {4'(h ^ 5), 4'(h)}, 8'(1 << (h % 8)), 7'(6 + h * 3)));
    end
    drain_outputs();

    // Random stream. It opens with a long receiver hold-off while items keep
    // coming, and its tail runs with no idling at all.
    hold_request   = 600;
    items_sent     = 0;
    mid_drain_done = 1'b0;
    while (items_sent < 1650) begin
      if (items_sent % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (items_sent >= 1500) quiet_tail = 1'b1;
      if (items_sent >= 800 && !mid_drain_done) begin
        drain_outputs();
        mid_drain_done = 1'b1;
      end
      r = random_report();
      send_report(r);
      items_sent++;
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    sb.errors += sb.outstanding();

    $display("Mapped %0d full reports and checked %0d output items; %0d short reports",
             sb.full_reports, sb.checked, sb.short_reports);
    $display("were dropped. Covered all hat codes, stick extremes, long back-pressure.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #10ms;
    $display("Timeout with %0d output items still owed.", sb.outstanding());
    $display("== FAIL ==");
    $finish;
  end

endmodule
